### design/byte_ring_fifo_macros.svh
// Assertion helpers shared by the RTL; clocked on clk, disabled during rst.
`ifndef BYTE_RING_FIFO_MACROS_SVH
`define BYTE_RING_FIFO_MACROS_SVH

// Same-cycle implication.
`define BRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte_ring_fifo: check failed");

// Next-cycle implication.
`define BRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte_ring_fifo: check failed");

`endif

### design/brf_pkg.sv
package brf_pkg;

  localparam int MAX_DEPTH_DEF = 256;

  localparam int KIND_W = 3;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 9;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT_BYTE = 3'd0,
    KIND_GET_BYTE = 3'd1,
    KIND_PUT_WORD = 3'd2,
    KIND_GET_WORD = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP2,
    S_RESULT
  } state_t;

endpackage

### design/brf_if.sv
interface brf_op_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::KIND_W-1:0]  kind;
  logic [brf_pkg::WORD_W-1:0]  write_value;

  modport source (output valid, output kind, output write_value, input ready);
  modport sink   (input valid, input kind, input write_value, output ready);
endinterface

interface brf_result_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [brf_pkg::WORD_W-1:0]  read_value;
  logic [brf_pkg::CNT_W-1:0]   filled_count;
  logic [brf_pkg::CNT_W-1:0]   free_count;

  modport source (output valid, output status, output read_value, output filled_count,
                  output free_count, input ready);
  modport sink   (input valid, input status, input read_value, input filled_count,
                  input free_count, output ready);
endinterface

interface brf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::CNT_W-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

### design/byte_ring_fifo.sv
// byte_ring_fifo: circular byte FIFO on a single-port byte memory.
// op channel: one item per operation (kind, write_value); cfg channel: the
// capacity register, always ready; the user writes it only while the block is
// idle; the block does not enforce this. result channel: one item per op
// (status, read_value, filled/free counts).
// Each op does at most one memory access per cycle:
//   byte put/get, clear, refused or unknown op: S_IDLE, then S_RESULT
//   16-bit put/get: S_IDLE, S_OP2, S_RESULT (two byte accesses to the one
//   memory port)
// The next op is taken the cycle after its result is loaded.
// A result sits in the output register until taken; while it waits the next
// op may be accepted and worked, and its result waits for the register.
// Reset: capacity 256, pointers and count zero, no result pending.
// Memory contents are not cleared; only stored bytes are ever read back.
// A capacity write (or a clear op) empties the buffer at once.
`include "byte_ring_fifo_macros.svh"

module byte_ring_fifo #(
  parameter int MAX_DEPTH = brf_pkg::MAX_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  brf_op_if.sink       op,
  brf_result_if.source result,
  brf_cfg_if.sink      cfg
);

  localparam int AW      = $clog2(MAX_DEPTH);
  localparam int CW      = brf_pkg::CNT_W;
  localparam int CMPW    = (AW + 1 > CW) ? AW + 1 : CW;
  localparam int CAP_MAX = (MAX_DEPTH > 511) ? 511 : MAX_DEPTH;
  localparam logic [CW-1:0] CAP_LIM = CW'(CAP_MAX);

  brf_pkg::state_t state, state_next;

  logic [CW-1:0]              capacity;
  logic [CW-1:0]              cap_eff;
  logic [CW-1:0]              count;
  logic [CW-1:0]              room;
  logic [AW-1:0]              rp, wp, rp_adv, wp_adv;
  logic [CMPW-1:0]            rp_plus, wp_plus, cap_wide;
  logic [brf_pkg::KIND_W-1:0] kind_r;
  logic [brf_pkg::BYTE_W-1:0] lo_byte;
  logic [brf_pkg::BYTE_W-1:0] rv_hi;
  logic                       status_r;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_addr;
  logic [brf_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  logic accept, wp_step, rp_step, cnt_inc, cnt_dec, clr, refuse, hi_load, res_load;
  logic ok_put1, ok_get1, ok_put2, ok_get2;

  assign cap_eff  = (capacity > CAP_LIM) ? CAP_LIM : capacity;
  assign room     = cap_eff - count;
  assign cap_wide = CMPW'(cap_eff);
  assign rp_plus  = CMPW'(rp) + CMPW'(1);
  assign wp_plus  = CMPW'(wp) + CMPW'(1);
  assign rp_adv   = (rp_plus >= cap_wide) ? '0 : rp_plus[AW-1:0];
  assign wp_adv   = (wp_plus >= cap_wide) ? '0 : wp_plus[AW-1:0];

  assign ok_put1 = count < cap_eff;
  assign ok_get1 = count != '0;
  assign ok_put2 = (count <= cap_eff) && (room >= CW'(2));
  assign ok_get2 = count >= CW'(2);

  assign accept    = op.valid && op.ready;
  assign cfg.ready = 1'b1;

  brf_mem #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op.ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = wp;
    mem_wdata  = lo_byte;
    wp_step    = 1'b0;
    rp_step    = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    clr        = 1'b0;
    refuse     = 1'b0;
    hi_load    = 1'b0;
    res_load   = 1'b0;
    case (state)
      brf_pkg::S_IDLE: begin
        op.ready = 1'b1;
        if (op.valid) begin
          state_next = brf_pkg::S_RESULT;
          case (op.kind)
            brf_pkg::KIND_PUT_BYTE: begin
              if (ok_put1) begin
                mem_we    = 1'b1;
                mem_wdata = op.write_value[7:0];
                wp_step   = 1'b1;
                cnt_inc   = 1'b1;
              end else begin
                refuse = 1'b1;
              end
            end
            brf_pkg::KIND_GET_BYTE: begin
              if (ok_get1) begin
                mem_re   = 1'b1;
                mem_addr = rp;
                rp_step  = 1'b1;
                cnt_dec  = 1'b1;
              end else begin
                refuse = 1'b1;
              end
            end
            brf_pkg::KIND_PUT_WORD: begin
              if (ok_put2) begin
                mem_we     = 1'b1;
                mem_wdata  = op.write_value[15:8];
                wp_step    = 1'b1;
                cnt_inc    = 1'b1;
                state_next = brf_pkg::S_OP2;
              end else begin
                refuse = 1'b1;
              end
            end
            brf_pkg::KIND_GET_WORD: begin
              if (ok_get2) begin
                mem_re     = 1'b1;
                mem_addr   = rp;
                rp_step    = 1'b1;
                cnt_dec    = 1'b1;
                state_next = brf_pkg::S_OP2;
              end else begin
                refuse = 1'b1;
              end
            end
            brf_pkg::KIND_CLEAR: begin
              clr = 1'b1;
            end
            default: begin
              refuse = 1'b1;
            end
          endcase
        end
      end
      brf_pkg::S_OP2: begin
        state_next = brf_pkg::S_RESULT;
        if (kind_r == brf_pkg::KIND_PUT_WORD) begin
          mem_we  = 1'b1;
          wp_step = 1'b1;
          cnt_inc = 1'b1;
        end else begin
          mem_re   = 1'b1;
          mem_addr = rp;
          rp_step  = 1'b1;
          cnt_dec  = 1'b1;
          hi_load  = 1'b1;
        end
      end
      brf_pkg::S_RESULT: begin
        if (!result.valid || result.ready) begin
          res_load   = 1'b1;
          state_next = brf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = brf_pkg::S_IDLE;
      end
    endcase
  end

  // pointers, count, capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= brf_pkg::CAP_RESET;
      rp       <= '0;
      wp       <= '0;
      count    <= '0;
    end else if (cfg.valid) begin
      capacity <= cfg.capacity;
      rp       <= '0;
      wp       <= '0;
      count    <= '0;
    end else if (clr) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      if (wp_step) begin
        wp <= wp_adv;
      end
      if (rp_step) begin
        rp <= rp_adv;
      end
      if (cnt_inc) begin
        count <= count + CW'(1);
      end else if (cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= op.kind;
      lo_byte  <= op.write_value[7:0];
      status_r <= refuse;
    end
    if (hi_load) begin
      rv_hi <= mem_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.status       <= status_r;
      result.filled_count <= count;
      result.free_count   <= (count <= cap_eff) ? room : '0;
      if (status_r) begin
        result.read_value <= '0;
      end else if (kind_r == brf_pkg::KIND_GET_BYTE) begin
        result.read_value <= {8'h00, mem_rdata};
      end else if (kind_r == brf_pkg::KIND_GET_WORD) begin
        result.read_value <= {rv_hi, mem_rdata};
      end else begin
        result.read_value <= '0;
      end
    end
  end

  `BRF_ASSERT_IMPL(a_count_in_cap, 1'b1, count <= cap_eff)
  `BRF_ASSERT_IMPL(a_ptr_meet, count == '0 || count == cap_eff, wp == rp)
  `BRF_ASSERT_IMPL(a_single_port, mem_we, !mem_re)
  `BRF_ASSERT_NEXT(a_one_at_a_time, accept, !op.ready)
  `BRF_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid)

endmodule

### design/brf_mem.sv
module brf_mem #(
  parameter int DEPTH = brf_pkg::MAX_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [brf_pkg::BYTE_W-1:0] wdata,
  output logic [brf_pkg::BYTE_W-1:0] rdata
);

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
